### sv/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
`default_nettype none
package stt_pkg;
    localparam int CNT_W_MAX = 32;
    localparam int POS_W_MAX = 48;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_OP      = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_DONE    = 3'd5
    } mode_t;

    localparam logic [4:0] TK_EOF    = 5'd0;
    localparam logic [4:0] TK_IDENT  = 5'd1;
    localparam logic [4:0] TK_NUMBER = 5'd2;
    localparam logic [4:0] TK_FN     = 5'd3;
    localparam logic [4:0] TK_LET    = 5'd4;
    localparam logic [4:0] TK_RETURN = 5'd5;
    localparam logic [4:0] TK_IF     = 5'd6;
    localparam logic [4:0] TK_ELSE   = 5'd7;
    localparam logic [4:0] TK_WHILE  = 5'd8;
    localparam logic [4:0] TK_ARROW  = 5'd9;
    localparam logic [4:0] TK_EQ     = 5'd10;
    localparam logic [4:0] TK_NE     = 5'd11;
    localparam logic [4:0] TK_LE     = 5'd12;
    localparam logic [4:0] TK_GE     = 5'd13;
    localparam logic [4:0] TK_LPAREN = 5'd14;
    localparam logic [4:0] TK_RPAREN = 5'd15;
    localparam logic [4:0] TK_LBRACE = 5'd16;
    localparam logic [4:0] TK_RBRACE = 5'd17;
    localparam logic [4:0] TK_COMMA  = 5'd18;
    localparam logic [4:0] TK_SEMI   = 5'd19;
    localparam logic [4:0] TK_COLON  = 5'd20;
    localparam logic [4:0] TK_PLUS   = 5'd21;
    localparam logic [4:0] TK_MINUS  = 5'd22;
    localparam logic [4:0] TK_STAR   = 5'd23;
    localparam logic [4:0] TK_SLASH  = 5'd24;
    localparam logic [4:0] TK_ASSIGN = 5'd25;
    localparam logic [4:0] TK_LT     = 5'd26;
    localparam logic [4:0] TK_GT     = 5'd27;
    localparam logic [4:0] TK_NONE   = 5'd0;

    localparam logic [47:0] KW_FN     = 48'h00000000_6e66;
    localparam logic [47:0] KW_LET    = 48'h0000_0074656c;
    localparam logic [47:0] KW_RETURN = 48'h6e72_75746572;
    localparam logic [47:0] KW_IF     = 48'h00000000_6669;
    localparam logic [47:0] KW_ELSE   = 48'h0000_65736c65;
    localparam logic [47:0] KW_WHILE  = 48'h0065_6c696877;

    typedef struct packed {
        logic                 vld;
        logic [4:0]           kind;
        logic [CNT_W_MAX-1:0] line;
        logic [CNT_W_MAX-1:0] column;
        logic [POS_W_MAX-1:0] offset;
        logic [CNT_W_MAX-1:0] length;
        logic                 last;
    } tok_t;

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        begin
            case (c)
                8'h28: k = TK_LPAREN;
                8'h29: k = TK_RPAREN;
                8'h7b: k = TK_LBRACE;
                8'h7d: k = TK_RBRACE;
                8'h2c: k = TK_COMMA;
                8'h3b: k = TK_SEMI;
                8'h3a: k = TK_COLON;
                8'h2b: k = TK_PLUS;
                8'h2d: k = TK_MINUS;
                8'h2a: k = TK_STAR;
                8'h2f: k = TK_SLASH;
                8'h3d: k = TK_ASSIGN;
                8'h3c: k = TK_LT;
                8'h3e: k = TK_GT;
                default: k = TK_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction
endpackage
`default_nettype wire

### sv/stt_scan.sv
// Tokenizer state registers and single-pass next-state and token logic.
`default_nettype none
module stt_scan import stt_pkg::*; #(
    parameter int POSITION_BITS = 32,
    parameter int COUNTER_BITS  = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire logic       in_end,
    input  wire logic [7:0] in_byte,
    output tok_t            tok0,
    output tok_t            tok1
);
    localparam logic [COUNTER_BITS-1:0]  CMAX = {COUNTER_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] PMAX = {POSITION_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0]  CONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};
    localparam logic [COUNTER_BITS-1:0]  CTWO = {{(COUNTER_BITS-2){1'b0}}, 2'd2};

    mode_t                    mode_reg, mode_next;
    logic [7:0]               pend_reg, pend_next;
    logic [47:0]              kw_reg, kw_next;
    logic [POSITION_BITS-1:0] tstart_reg, tstart_next;
    logic [COUNTER_BITS-1:0]  tsize_reg, tsize_next;
    logic [COUNTER_BITS-1:0]  tline_reg, tline_next;
    logic [COUNTER_BITS-1:0]  tcol_reg, tcol_next;
    logic [COUNTER_BITS-1:0]  cline_reg, cline_next;
    logic [COUNTER_BITS-1:0]  ccol_reg, ccol_next;
    logic [POSITION_BITS-1:0] bpos_reg, bpos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= '0;
            kw_reg     <= '0;
            tstart_reg <= '0;
            tsize_reg  <= '0;
            tline_reg  <= CONE;
            tcol_reg   <= CONE;
            cline_reg  <= CONE;
            ccol_reg   <= CONE;
            bpos_reg   <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            kw_reg     <= kw_next;
            tstart_reg <= tstart_next;
            tsize_reg  <= tsize_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            cline_reg  <= cline_next;
            ccol_reg   <= ccol_next;
            bpos_reg   <= bpos_next;
        end
    end

    function automatic logic [COUNTER_BITS-1:0] inc1(input logic [COUNTER_BITS-1:0] v);
        return (v == CMAX) ? CMAX : v + CONE;
    endfunction

    function automatic logic [COUNTER_BITS-1:0] inc2(input logic [COUNTER_BITS-1:0] v);
        return (v >= CMAX - CONE) ? CMAX : v + CTWO;
    endfunction

    always_comb begin
        logic       ends;
        logic       more;
        logic       do_idle;
        logic [4:0] two;
        logic [4:0] wk;
        logic [4:0] ek;
        logic       emit_p;
        logic       emit_eof;
        logic       do_reset;
        tok_t       tp;
        tok_t       te;
        ends     = in_end || (in_byte == 8'h00);
        more     = 1'b0;
        do_idle  = 1'b0;
        two      = TK_NONE;
        wk       = TK_IDENT;
        ek       = TK_NONE;
        emit_p   = 1'b0;
        emit_eof = 1'b0;
        do_reset = 1'b0;
        tp       = '0;
        te       = '0;
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        kw_next     = kw_reg;
        tstart_next = tstart_reg;
        tsize_next  = tsize_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        cline_next  = cline_reg;
        ccol_next   = ccol_reg;
        bpos_next   = bpos_reg;

        if (tsize_reg <= COUNTER_BITS'(6)) begin
            if (kw_reg == KW_FN && tsize_reg == COUNTER_BITS'(2))          wk = TK_FN;
            else if (kw_reg == KW_LET && tsize_reg == COUNTER_BITS'(3))    wk = TK_LET;
            else if (kw_reg == KW_RETURN && tsize_reg == COUNTER_BITS'(6)) wk = TK_RETURN;
            else if (kw_reg == KW_IF && tsize_reg == COUNTER_BITS'(2))     wk = TK_IF;
            else if (kw_reg == KW_ELSE && tsize_reg == COUNTER_BITS'(4))   wk = TK_ELSE;
            else if (kw_reg == KW_WHILE && tsize_reg == COUNTER_BITS'(5))  wk = TK_WHILE;
        end

        case (mode_reg)
            MODE_DONE: begin
                if (in_end) begin
                    do_reset = 1'b1;
                end
            end
            MODE_IDENT, MODE_NUMBER: begin
                more = (mode_reg == MODE_IDENT) ? (is_letter(in_byte) || is_digit(in_byte))
                                                : is_digit(in_byte);
                if (!ends && more) begin
                    case (tsize_reg)
                        COUNTER_BITS'(1): kw_next[15:8]  = in_byte;
                        COUNTER_BITS'(2): kw_next[23:16] = in_byte;
                        COUNTER_BITS'(3): kw_next[31:24] = in_byte;
                        COUNTER_BITS'(4): kw_next[39:32] = in_byte;
                        COUNTER_BITS'(5): kw_next[47:40] = in_byte;
                        default: kw_next = kw_reg;
                    endcase
                    tsize_next = inc1(tsize_reg);
                    ccol_next  = inc1(ccol_reg);
                    if (bpos_reg != PMAX) bpos_next = bpos_reg + 1'b1;
                end else begin
                    emit_p    = 1'b1;
                    ek        = (mode_reg == MODE_IDENT) ? wk : TK_NUMBER;
                    mode_next = MODE_IDLE;
                    do_idle   = 1'b1;
                end
            end
            MODE_OP: begin
                if (pend_reg == 8'h2d && in_byte == 8'h3e)      two = TK_ARROW;
                else if (in_byte == 8'h3d && pend_reg == 8'h3d) two = TK_EQ;
                else if (in_byte == 8'h3d && pend_reg == 8'h21) two = TK_NE;
                else if (in_byte == 8'h3d && pend_reg == 8'h3c) two = TK_LE;
                else if (in_byte == 8'h3d && pend_reg == 8'h3e) two = TK_GE;
                if (!ends && pend_reg == 8'h2f && in_byte == 8'h2f) begin
                    mode_next = MODE_COMMENT;
                    if (bpos_reg != PMAX) bpos_next = bpos_reg + 1'b1;
                end else if (!ends && two != TK_NONE) begin
                    tsize_next = CTWO;
                    emit_p     = 1'b1;
                    ek         = two;
                    ccol_next  = inc2(ccol_reg);
                    if (bpos_reg != PMAX) bpos_next = bpos_reg + 1'b1;
                    mode_next  = MODE_IDLE;
                end else begin
                    if (pend_reg != 8'h21) begin
                        tsize_next = CONE;
                        emit_p     = 1'b1;
                        ek         = single_kind(pend_reg);
                    end
                    ccol_next = inc1(ccol_reg);
                    mode_next = MODE_IDLE;
                    do_idle   = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (!ends && in_byte != 8'h0a) begin
                    if (bpos_reg != PMAX) bpos_next = bpos_reg + 1'b1;
                end else begin
                    mode_next = MODE_IDLE;
                    do_idle   = 1'b1;
                end
            end
            default: do_idle = 1'b1;
        endcase

        tp.vld    = emit_p;
        tp.kind   = ek;
        tp.line   = CNT_W_MAX'(tline_reg);
        tp.column = CNT_W_MAX'(tcol_reg);
        tp.offset = POS_W_MAX'(tstart_reg);
        tp.length = CNT_W_MAX'(tsize_next);

        if (do_idle) begin
            if (ends) begin
                emit_eof  = 1'b1;
                te.vld    = 1'b1;
                te.kind   = TK_EOF;
                te.line   = CNT_W_MAX'(cline_next);
                te.column = CNT_W_MAX'(ccol_next);
                te.offset = POS_W_MAX'(bpos_next);
                te.length = '0;
                if (in_end) do_reset = 1'b1;
                else        mode_next = MODE_DONE;
            end else begin
                tstart_next = bpos_next;
                tline_next  = cline_next;
                tcol_next   = ccol_next;
                if (bpos_next != PMAX) bpos_next = bpos_next + 1'b1;
                if (in_byte == 8'h0a) begin
                    cline_next = inc1(cline_next);
                    ccol_next  = CONE;
                end else if (in_byte == 8'h20 || in_byte == 8'h09 || in_byte == 8'h0d) begin
                    ccol_next = inc1(ccol_next);
                end else if (is_letter(in_byte) || is_digit(in_byte)) begin
                    mode_next  = is_letter(in_byte) ? MODE_IDENT : MODE_NUMBER;
                    tsize_next = CONE;
                    kw_next    = {40'd0, in_byte};
                    ccol_next  = inc1(ccol_next);
                end else if (in_byte == 8'h2d || in_byte == 8'h3d || in_byte == 8'h21 ||
                             in_byte == 8'h3c || in_byte == 8'h3e || in_byte == 8'h2f) begin
                    mode_next = MODE_OP;
                    pend_next = in_byte;
                end else begin
                    if (single_kind(in_byte) != TK_NONE) begin
                        tsize_next = CONE;
                        te.vld     = 1'b1;
                        te.kind    = single_kind(in_byte);
                        te.line    = CNT_W_MAX'(tline_next);
                        te.column  = CNT_W_MAX'(tcol_next);
                        te.offset  = POS_W_MAX'(tstart_next);
                        te.length  = CNT_W_MAX'(CONE);
                    end
                    ccol_next = inc1(ccol_next);
                end
            end
        end

        if (do_reset) begin
            mode_next   = MODE_IDLE;
            pend_next   = '0;
            kw_next     = '0;
            tstart_next = '0;
            tsize_next  = '0;
            tline_next  = CONE;
            tcol_next   = CONE;
            cline_next  = CONE;
            ccol_next   = CONE;
            bpos_next   = '0;
        end

        if (tp.vld) begin
            tok0      = tp;
            tok0.last = !te.vld;
            tok1      = te;
            tok1.last = te.vld;
        end else begin
            tok0      = te;
            tok0.last = te.vld;
            tok1      = '0;
        end
        if (emit_eof && !emit_p) tok0.last = 1'b1;
    end
endmodule
`default_nettype wire

### sv/stt_outq.sv
// Four-entry token queue: up to two pushes and one pop per cycle.
`default_nettype none
module stt_outq import stt_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  tok_t      din0,
    input  tok_t      din1,
    output logic      room,
    output logic      out_vld,
    input  wire logic out_rdy,
    output tok_t      dout
);
    tok_t       mem [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic       w0, w1;

    assign pop     = out_vld && out_rdy;
    assign out_vld = (cnt_reg != 3'd0);
    assign room    = (cnt_reg <= 3'd2) || (cnt_reg == 3'd3 && out_rdy);
    assign dout    = mem[rd_reg];
    assign w0      = push && din0.vld;
    assign w1      = push && din1.vld;

    always_comb begin
        wr_next  = wr_reg + {1'b0, w0} + {1'b0, w1};
        cnt_next = cnt_reg + {2'b0, w0} + {2'b0, w1} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (w0) mem[wr_reg] <= din0;
        if (w1) mem[wr_reg + 2'd1] <= din1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
            if (pop) rd_reg <= rd_reg + 2'd1;
        end
    end
endmodule
`default_nettype wire

### sv/source_text_tokenizer_unit.sv
// Top level of the streaming source text tokenizer.
// s_ channel: one source byte (s_kind=0) or an end marker (s_kind=1) per transfer.
// m_ channel: tokens with kind, line, column, start offset, length and last.
// The scanner updates its state in the cycle a byte is taken; tokens it
// produces are registered in a four-entry queue and reach m_ from there,
// behind any tokens already queued. Throughput: one byte per cycle while
// s_ready is high; a byte that yields two tokens leaves the single-token-per-cycle
// output one token at a time, set by the queue's read port.
// s_ready drops when the queue cannot take two more tokens, so a stalled
// receiver backs up the input after at most four tokens are buffered.
// Reset (aresetn low, synchronous) empties the queue and returns position
// counters to line 1, column 1, offset 0.
// An end marker or a NUL byte flushes any pending token and emits Eof with
// last set; bytes after a NUL are dropped until the end marker.
`default_nettype none
module source_text_tokenizer_unit import stt_pkg::*; #(
    parameter int POSITION_BITS = 32,
    parameter int COUNTER_BITS  = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_kind,
    input  wire logic [7:0]               s_byte_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [4:0]                    m_token_kind,
    output logic [COUNTER_BITS-1:0]       m_token_line,
    output logic [COUNTER_BITS-1:0]       m_token_column,
    output logic [POSITION_BITS-1:0]      m_start_offset,
    output logic [COUNTER_BITS-1:0]       m_token_length,
    output logic                          m_last
);
    tok_t tok0, tok1, head;
    logic fire;

    assign fire = s_valid && s_ready;

    stt_scan #(
        .POSITION_BITS(POSITION_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_scan (
        .aclk   (aclk),
        .aresetn(aresetn),
        .fire   (fire),
        .in_end (s_kind),
        .in_byte(s_byte_value),
        .tok0   (tok0),
        .tok1   (tok1)
    );

    stt_outq u_outq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (fire),
        .din0   (tok0),
        .din1   (tok1),
        .room   (s_ready),
        .out_vld(m_valid),
        .out_rdy(m_ready),
        .dout   (head)
    );

    assign m_token_kind   = head.kind;
    assign m_token_line   = head.line[COUNTER_BITS-1:0];
    assign m_token_column = head.column[COUNTER_BITS-1:0];
    assign m_start_offset = head.offset[POSITION_BITS-1:0];
    assign m_token_length = head.length[COUNTER_BITS-1:0];
    assign m_last         = head.last;
endmodule
`default_nettype wire

### sv/stt_checker.sv
// Port-level checks for the tokenizer, bound to the top level.
`default_nettype none
module stt_checker import stt_pkg::*; #(
    parameter int POSITION_BITS = 32,
    parameter int COUNTER_BITS  = 16
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic [4:0]               m_token_kind,
    input wire logic [COUNTER_BITS-1:0]  m_token_line,
    input wire logic [COUNTER_BITS-1:0]  m_token_column,
    input wire logic [POSITION_BITS-1:0] m_start_offset,
    input wire logic [COUNTER_BITS-1:0]  m_token_length,
    input wire logic                     m_last
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) && $stable(m_start_offset))
        else $error("token changed while stalled");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind <= TK_GT)
        else $error("token kind out of range");

    a_eof_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == TK_EOF |-> m_token_length == '0 && m_last)
        else $error("bad eof token");

    a_pos_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_line != '0 && m_token_column != '0)
        else $error("zero line or column");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
endmodule

bind source_text_tokenizer_unit stt_checker #(
    .POSITION_BITS(POSITION_BITS),
    .COUNTER_BITS (COUNTER_BITS)
) u_stt_checker (.*);
`default_nettype wire
